// ----- sv/kflh_pkg.sv -----
// ----------------------------------------------------------------------------
// kflh_pkg
// Shared types, constants and lane functions for the keyed four-lane hash.
// ----------------------------------------------------------------------------
`default_nettype none

package kflh_pkg;

  localparam logic [63:0] SEED_ONE   = 64'h0123456789ABCDEF;
  localparam logic [63:0] SEED_TWO   = 64'hFEDCBA9876543210;
  localparam logic [63:0] SEED_THREE = 64'h0F1E2D3C4B5A6978;
  localparam logic [63:0] SEED_FOUR  = 64'h8877665544332211;
  localparam logic [63:0] MIX_ONE    = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_TWO    = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] MIX_THREE  = 64'h165667B19E3779F9;
  localparam logic [63:0] MIX_FOUR   = 64'hD6E8FEB86659FD93;
  localparam logic [63:0] FIN_MUL_A  = 64'hFF51AFD7ED558CCD;
  localparam logic [63:0] FIN_MUL_B  = 64'hC4CEB9FE1A85EC53;

  localparam logic [1:0] REG_KEY_A = 2'd0;
  localparam logic [1:0] REG_KEY_B = 2'd1;
  localparam logic [1:0] REG_KEY_C = 2'd2;
  localparam logic [1:0] REG_KEY_D = 2'd3;

  localparam logic [1:0] LANE_ONE   = 2'd0;
  localparam logic [1:0] LANE_TWO   = 2'd1;
  localparam logic [1:0] LANE_THREE = 2'd2;
  localparam logic [1:0] LANE_FOUR  = 2'd3;

  localparam logic [1:0] MSTEP_LAST = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_UPD,
    ST_FLOAD,
    ST_FMUL,
    ST_FDONE
  } kflh_state_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } kflh_keys_t;

  typedef struct packed {
    logic       take;
    logic       seed;
    logic       mix;
    logic       upd;
    logic [1:0] lane;
    logic       fload;
    logic       half;
    logic       fmul;
    logic [1:0] mstep;
    logic       ksel;
    logic       hold_low;
    logic       out_load;
  } kflh_cmd_t;

  // byte + constant + shifted neighbor terms
  function automatic logic [63:0] mix_term(input logic [1:0] idx, input logic [63:0] x,
                                           input logic [7:0] b);
    logic [63:0] ext;
    ext = {56'd0, b};
    case (idx)
      LANE_ONE:   mix_term = ext + MIX_ONE   + (x << 6) + (x >> 2);
      LANE_TWO:   mix_term = ext + MIX_TWO   + (x << 7) + (x >> 3);
      LANE_THREE: mix_term = ext + MIX_THREE + (x << 5) + (x >> 4);
      default:    mix_term = ext + MIX_FOUR  + (x << 9) + (x >> 5);
    endcase
  endfunction

  function automatic logic [63:0] rot_term(input logic [1:0] idx, input logic [63:0] v);
    case (idx)
      LANE_ONE:   rot_term = {v[50:0], v[63:51]};
      LANE_TWO:   rot_term = {v[46:0], v[63:47]};
      LANE_THREE: rot_term = {v[52:0], v[63:53]};
      default:    rot_term = {v[44:0], v[63:45]};
    endcase
  endfunction

  function automatic logic [63:0] xorshift33(input logic [63:0] v);
    xorshift33 = v ^ (v >> 33);
  endfunction

endpackage

`default_nettype wire

// ----- sv/kflh_dp.sv -----
// ----------------------------------------------------------------------------
// kflh_dp
// Lane registers, shared lane update unit and 32x32 finalizer multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module kflh_dp (
  input  wire logic               clk,
  input  wire kflh_pkg::kflh_cmd_t cmd,
  input  wire kflh_pkg::kflh_keys_t keys,
  input  wire logic [7:0]         data_byte,
  output logic [63:0]             digest_low,
  output logic [63:0]             digest_high
);

  logic [7:0]  data_q;
  logic [63:0] lane_one, lane_two, lane_three, lane_four;
  logic [63:0] mix;
  logic [63:0] own, nx, ny;
  logic [63:0] upd_val;

  logic [63:0] fin_x;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [63:0] hold;
  logic [63:0] fin_src;
  logic [63:0] kmul;
  logic [31:0] ma, mb;
  logic [63:0] mp;
  logic [31:0] acc_hi_sum;

  always_comb begin
    case (cmd.lane)
      kflh_pkg::LANE_ONE: begin
        own = lane_one;   nx = lane_two;   ny = lane_three;
      end
      kflh_pkg::LANE_TWO: begin
        own = lane_two;   nx = lane_three; ny = lane_four;
      end
      kflh_pkg::LANE_THREE: begin
        own = lane_three; nx = lane_four;  ny = lane_one;
      end
      default: begin
        own = lane_four;  nx = lane_one;   ny = lane_two;
      end
    endcase
  end

  assign upd_val = kflh_pkg::rot_term(cmd.lane, own ^ mix) + ny;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      data_q <= data_byte;
    end
    if (cmd.mix) begin
      mix <= kflh_pkg::mix_term(cmd.lane, nx, data_q);
    end
    if (cmd.seed) begin
      lane_one   <= kflh_pkg::SEED_ONE   ^ keys.a;
      lane_two   <= kflh_pkg::SEED_TWO   ^ keys.b;
      lane_three <= kflh_pkg::SEED_THREE ^ keys.c;
      lane_four  <= kflh_pkg::SEED_FOUR  ^ keys.d;
    end else if (cmd.upd) begin
      case (cmd.lane)
        kflh_pkg::LANE_ONE:   lane_one   <= upd_val;
        kflh_pkg::LANE_TWO:   lane_two   <= upd_val;
        kflh_pkg::LANE_THREE: lane_three <= upd_val;
        default:              lane_four  <= upd_val;
      endcase
    end
  end

  // finalizer: x*K mod 2^64 from three 32x32 partial products
  assign fin_src    = cmd.half ? (lane_two ^ lane_four) : (lane_one ^ lane_three);
  assign kmul       = cmd.ksel ? kflh_pkg::FIN_MUL_B : kflh_pkg::FIN_MUL_A;
  assign ma         = (cmd.mstep == 2'd2) ? fin_x[63:32] : fin_x[31:0];
  assign mb         = (cmd.mstep == 2'd1) ? kmul[63:32] : kmul[31:0];
  assign mp         = {32'd0, ma} * {32'd0, mb};
  assign acc_hi_sum = acc[63:32] + prod[31:0];

  always_ff @(posedge clk) begin
    if (cmd.fload) begin
      fin_x <= kflh_pkg::xorshift33(fin_src);
    end else if (cmd.fmul) begin
      case (cmd.mstep)
        2'd0: begin
          prod <= mp;
        end
        2'd1: begin
          prod <= mp;
          acc  <= prod;
        end
        2'd2: begin
          prod       <= mp;
          acc[63:32] <= acc_hi_sum;
        end
        default: begin
          fin_x <= kflh_pkg::xorshift33({acc_hi_sum, acc[31:0]});
        end
      endcase
    end
    if (cmd.hold_low) begin
      hold <= fin_x;
    end
    if (cmd.out_load) begin
      digest_low  <= hold;
      digest_high <= fin_x;
    end
  end

endmodule

`default_nettype wire

// ----- sv/kflh_ctrl.sv -----
// ----------------------------------------------------------------------------
// kflh_ctrl
// Sequencer: request intake, lane update steps, finalizer steps, result slot.
// ----------------------------------------------------------------------------
`default_nettype none

module kflh_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                has_byte,
  input  wire logic                last_byte,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output kflh_pkg::kflh_cmd_t      cmd
);

  kflh_pkg::kflh_state_t state, state_next;

  logic       need_seed;
  logic       last_q;
  logic [1:0] lane_idx;
  logic [1:0] mstep;
  logic       ksel;
  logic       half;
  logic       accept;
  logic       out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      kflh_pkg::ST_IDLE: begin
        if (accept) begin
          if (has_byte) begin
            state_next = kflh_pkg::ST_MIX;
          end else if (last_byte) begin
            state_next = kflh_pkg::ST_FLOAD;
          end
        end
      end
      kflh_pkg::ST_MIX: begin
        state_next = kflh_pkg::ST_UPD;
      end
      kflh_pkg::ST_UPD: begin
        if (lane_idx != kflh_pkg::LANE_FOUR) begin
          state_next = kflh_pkg::ST_MIX;
        end else if (last_q) begin
          state_next = kflh_pkg::ST_FLOAD;
        end else begin
          state_next = kflh_pkg::ST_IDLE;
        end
      end
      kflh_pkg::ST_FLOAD: begin
        state_next = kflh_pkg::ST_FMUL;
      end
      kflh_pkg::ST_FMUL: begin
        if (mstep == kflh_pkg::MSTEP_LAST && ksel) begin
          state_next = kflh_pkg::ST_FDONE;
        end
      end
      kflh_pkg::ST_FDONE: begin
        if (!half) begin
          state_next = kflh_pkg::ST_FLOAD;
        end else if (out_free) begin
          state_next = kflh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kflh_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.lane     = lane_idx;
    cmd.half     = half;
    cmd.mstep    = mstep;
    cmd.ksel     = ksel;
    case (state)
      kflh_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = accept;
        cmd.seed = accept && need_seed;
      end
      kflh_pkg::ST_MIX: begin
        cmd.mix = 1'b1;
      end
      kflh_pkg::ST_UPD: begin
        cmd.upd = 1'b1;
      end
      kflh_pkg::ST_FLOAD: begin
        cmd.fload = 1'b1;
      end
      kflh_pkg::ST_FMUL: begin
        cmd.fmul = 1'b1;
      end
      kflh_pkg::ST_FDONE: begin
        cmd.hold_low = !half;
        cmd.out_load = half && out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kflh_pkg::ST_IDLE;
      need_seed <= 1'b1;
      out_valid <= 1'b0;
      last_q    <= 1'b0;
      lane_idx  <= 2'd0;
      mstep     <= 2'd0;
      ksel      <= 1'b0;
      half      <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        need_seed <= last_byte;
        last_q    <= last_byte;
        lane_idx  <= kflh_pkg::LANE_ONE;
        half      <= 1'b0;
      end
      if (cmd.upd) begin
        lane_idx <= lane_idx + 2'd1;
      end
      if (cmd.fload) begin
        mstep <= 2'd0;
        ksel  <= 1'b0;
      end
      if (cmd.fmul) begin
        mstep <= mstep + 2'd1;
        if (mstep == kflh_pkg::MSTEP_LAST) begin
          ksel <= 1'b1;
        end
      end
      if (cmd.hold_low) begin
        half <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result slot overwritten while held");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.mix, cmd.upd, cmd.fload, cmd.fmul, cmd.hold_low, cmd.out_load}))
    else $error("more than one datapath command");

  a_marker_only: assert property (@(posedge clk) disable iff (rst)
    (accept && !has_byte && !last_byte) |=> state == kflh_pkg::ST_IDLE)
    else $error("marker without last did not return to idle");

  a_fin_done: assert property (@(posedge clk) disable iff (rst)
    (state == kflh_pkg::ST_FMUL && ksel && mstep == kflh_pkg::MSTEP_LAST)
      |=> state == kflh_pkg::ST_FDONE)
    else $error("finalizer sequence did not complete");

  a_seed_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> need_seed)
    else $error("next message not marked for seeding");

endmodule

`default_nettype wire

// ----- sv/keyed_four_lane_byte_hash.sv -----
// ----------------------------------------------------------------------------
// keyed_four_lane_byte_hash
// Keyed 128-bit hash over a byte stream, key set over an APB-style port.
// ----------------------------------------------------------------------------
// Usage:
//   Write the four 64-bit key words at byte addresses 0, 8, 16, 24 while idle.
//   Send message bytes as requests on in_valid/in_ready (data_byte, has_byte,
//   last_byte). An empty message is one request with has_byte=0, last_byte=1.
//   A byte request occupies the block for an intake step, then a mix step and
//   an update step per lane for the four dependent lane updates through one
//   shared add/rotate unit. A byteless request needs only the intake step.
//   On last_byte the finalizer then runs (two halves, each three
//   32x32 partial products per multiply through one shared multiplier), then
//   digest_low/digest_high appear with out_valid.
//   The digest waits in an output register; the next request is taken while
//   it waits. If the receiver still stalls when the next digest is finished,
//   the block holds until out_ready frees the register.
//   Reset clears the keys to zero, drops out_valid and marks the lanes to be
//   seeded on the first request.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_four_lane_byte_hash (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        has_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      digest_low,
  output logic [63:0]      digest_high
);

  kflh_pkg::kflh_keys_t keys;
  kflh_pkg::kflh_cmd_t  cmd;
  logic                 reg_wr;
  logic [1:0]           reg_idx;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        kflh_pkg::REG_KEY_A: keys.a <= pwdata;
        kflh_pkg::REG_KEY_B: keys.b <= pwdata;
        kflh_pkg::REG_KEY_C: keys.c <= pwdata;
        default:             keys.d <= pwdata;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      kflh_pkg::REG_KEY_A: prdata = keys.a;
      kflh_pkg::REG_KEY_B: prdata = keys.b;
      kflh_pkg::REG_KEY_C: prdata = keys.c;
      default:             prdata = keys.d;
    endcase
  end

  kflh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .has_byte  (has_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  kflh_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .keys        (keys),
    .data_byte   (data_byte),
    .digest_low  (digest_low),
    .digest_high (digest_high)
  );

endmodule

`default_nettype wire

// ----- test/tb_keyed_four_lane_byte_hash.sv -----
// ----------------------------------------------------------------------------
// tb_keyed_four_lane_byte_hash
// Self-checking bench for the keyed four-lane byte hash. A lane-level model
// predicts the digest of every message. Directed messages cover empty
// messages, lone markers, extreme bytes and a key change inside an open
// message. Random messages of varied length then run under several key
// settings. Both handshakes see random stalls, and the APB key registers are
// read back after each write.
// ----------------------------------------------------------------------------
module tb_keyed_four_lane_byte_hash;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [63:0] low;
    logic [63:0] high;
  } digest_t;

  class digest_scoreboard;
    logic [63:0] key_word [4];
    logic [63:0] lane_one, lane_two, lane_three, lane_four;
    bit need_seed;
    digest_t expected_digests [$];
    int mismatches;
    int digests_checked;
    int requests_taken;

    function new();
      foreach (key_word[i]) key_word[i] = '0;
      lane_one = '0;
      lane_two = '0;
      lane_three = '0;
      lane_four = '0;
      need_seed = 1'b1;
      mismatches = 0;
      digests_checked = 0;
      requests_taken = 0;
    endfunction

    function void set_key(logic [1:0] idx, logic [63:0] value);
      key_word[idx] = value;
    endfunction

    function logic [63:0] rotl(logic [63:0] x, int n);
      return (x << n) | (x >> (64 - n));
    endfunction

    function logic [63:0] avalanche(logic [63:0] x);
      logic [63:0] v;
      v = x ^ (x >> 33);
      v = v * kflh_pkg::FIN_MUL_A;
      v = v ^ (v >> 33);
      v = v * kflh_pkg::FIN_MUL_B;
      v = v ^ (v >> 33);
      return v;
    endfunction

    function void note_request(logic [7:0] b, logic has, logic last);
      logic [63:0] ext;
      digest_t d;
      ext = {56'd0, b};
      requests_taken++;
      if (need_seed) begin
        lane_one = kflh_pkg::SEED_ONE ^ key_word[kflh_pkg::REG_KEY_A];
        lane_two = kflh_pkg::SEED_TWO ^ key_word[kflh_pkg::REG_KEY_B];
        lane_three = kflh_pkg::SEED_THREE ^ key_word[kflh_pkg::REG_KEY_C];
        lane_four = kflh_pkg::SEED_FOUR ^ key_word[kflh_pkg::REG_KEY_D];
        need_seed = 1'b0;
      end
      if (has) begin
        lane_one = lane_one ^
                   (ext + kflh_pkg::MIX_ONE + (lane_two << 6) + (lane_two >> 2));
        lane_one = rotl(lane_one, 13) + lane_three;
        lane_two = lane_two ^
                   (ext + kflh_pkg::MIX_TWO + (lane_three << 7) + (lane_three >> 3));
        lane_two = rotl(lane_two, 17) + lane_four;
        lane_three = lane_three ^
                     (ext + kflh_pkg::MIX_THREE + (lane_four << 5) + (lane_four >> 4));
        lane_three = rotl(lane_three, 11) + lane_one;
        lane_four = lane_four ^
                    (ext + kflh_pkg::MIX_FOUR + (lane_one << 9) + (lane_one >> 5));
        lane_four = rotl(lane_four, 19) + lane_two;
      end
      if (last) begin
        d.low = avalanche(lane_one ^ lane_three);
        d.high = avalanche(lane_two ^ lane_four);
        expected_digests.push_back(d);
        need_seed = 1'b1;
      end
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h want %h", what, got, want);
      mismatches++;
    endtask

    task check_digest(logic [63:0] low, logic [63:0] high);
      digest_t d;
      if (expected_digests.size() == 0) begin
        report_mismatch("unexpected digest_low", low, '0);
      end else begin
        d = expected_digests.pop_front();
        digests_checked++;
        if (low !== d.low) report_mismatch("digest_low", low, d.low);
        if (high !== d.high) report_mismatch("digest_high", high, d.high);
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] digest_low;
  logic [63:0] digest_high;

  digest_scoreboard sb;
  bit quiet_run;
  int cycle_count;
  int key_settings;

  keyed_four_lane_byte_hash uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .has_byte(has_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .digest_low(digest_low),
    .digest_high(digest_high)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // digest receiver with random stall bursts
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_digest(digest_low, digest_high);
  end

  task automatic send_request(input logic [7:0] b, input logic has, input logic last);
    int gap;
    gap = 0;
    if (!quiet_run && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    has_byte <= has;
    last_byte <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_request(b, has, last);
  endtask

  // drain: nothing expected, then let marker-only work settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic key_write(input logic [1:0] idx, input logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_key(idx, value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) sb.report_mismatch("key readback", prdata, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_keys(input logic [63:0] a, input logic [63:0] b,
                          input logic [63:0] c, input logic [63:0] d);
    key_write(kflh_pkg::REG_KEY_A, a);
    key_write(kflh_pkg::REG_KEY_B, b);
    key_write(kflh_pkg::REG_KEY_C, c);
    key_write(kflh_pkg::REG_KEY_D, d);
    key_settings++;
  endtask

  task automatic run_messages(input int request_goal);
    int sent;
    int len;
    int pick;
    bit close_empty;
    sent = 0;
    while (sent < request_goal) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_request(8'($urandom), 1'b0, 1'b1);
        sent++;
      end else begin
        len = (pick == 1) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        close_empty = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_request(8'($urandom), 1'b0, 1'b0);
            sent++;
          end
          send_request(8'($urandom), 1'b1, (i == len - 1) && !close_empty);
          sent++;
        end
        if (close_empty) begin
          send_request(8'($urandom), 1'b0, 1'b1);
          sent++;
        end
      end
    end
  endtask

  initial begin
    sb = new();
    quiet_run = 1'b0;
    cycle_count = 0;
    key_settings = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    data_byte = '0;
    has_byte = 1'b0;
    last_byte = 1'b0;
    out_ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, keys at reset value
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hFF, 1'b1, 1'b1);
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'h80, 1'b1, 1'b0);
    send_request(8'h01, 1'b1, 1'b1);
    send_request(8'h55, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'hAA, 1'b1, 1'b1);
    send_request(8'h7F, 1'b0, 1'b1);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hFE, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);

    // key change inside an open message: lanes keep the old seed
    send_request(8'h12, 1'b1, 1'b0);
    wait_idle();
    set_keys('1, '1, '1, '1);
    send_request(8'h34, 1'b1, 1'b1);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hC3, 1'b1, 1'b1);
    wait_idle();

    set_keys({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom});
    run_messages(130);
    wait_idle();
    set_keys('0, '0, '0, '0);
    run_messages(130);
    wait_idle();
    set_keys({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom});
    run_messages(130);
    wait_idle();
    set_keys({32{2'b10}}, {32{2'b01}}, {$urandom, $urandom}, {8{8'hF0}});
    run_messages(130);
    wait_idle();
    set_keys('1, '1, '1, '1);
    quiet_run = 1'b1;
    run_messages(130);
    wait_idle();

    $display("Covered %0d requests and %0d digests under %0d key settings,",
             sb.requests_taken, sb.digests_checked, key_settings + 1);
    $display("with empty messages, stray markers and a mid-message key change.");
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
